// ===== src/lvm_pkg.sv =====
// lvm_pkg: shared types and fixed constants for the look-at view matrix pipeline
// no dependencies; used by lvm_unit, lookat_view_matrix and lvm_checker
package lvm_pkg;

    // the largest normalized magnitude of a vector lies in [2^NORM_MSB, 2^(NORM_MSB+1))
    localparam int NORM_MSB = 29;
    localparam int NORM_W   = NORM_MSB + 1;
    localparam int SCALED_W = NORM_W + 1;
    localparam int SQ_W     = 2 * NORM_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = SUM_W / 2;

    localparam int ROW_W = 2;
    localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
    localparam logic [ROW_W-1:0] ROW_LAST  = 2'd3;

    typedef struct packed {
        logic vld;
        logic ok;
    } t_unit_st;

endpackage

// ===== src/lvm_unit.sv =====
// lvm_unit: pipelined vector normalizer (power-of-two prescale, square root, rounded divide)
// depends on lvm_pkg; one stage per root bit and per quotient bit
module lvm_unit #(
    parameter int IN_W      = 33,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [3*IN_W-1:0]             i_vec,
    input  logic [SIDE_W-1:0]             i_side,
    output lvm_pkg::t_unit_st             o_st,
    output logic [3*(FRAC_BITS+2)-1:0]    o_vec,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int NORM_MSB = lvm_pkg::NORM_MSB;
    localparam int NORM_W   = lvm_pkg::NORM_W;
    localparam int SQ_W     = lvm_pkg::SQ_W;
    localparam int SUM_W    = lvm_pkg::SUM_W;
    localparam int ROOT_W   = lvm_pkg::ROOT_W;
    localparam int PW       = $clog2(IN_W);
    localparam int QW       = FRAC_BITS + 1;
    localparam int UW       = FRAC_BITS + 2;
    localparam int NW       = NORM_W + 1 + FRAC_BITS;
    localparam int DW       = NW + 1;
    localparam int LAT      = 5 + ROOT_W + 1 + QW + 1;

    logic [LAT-1:0]    r_vld;
    logic [SIDE_W-1:0] r_side [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 1; i < LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // magnitudes and their common or
    logic [IN_W-1:0] n1_mag [0:2];
    logic [2:0]      n1_neg;
    logic [IN_W-1:0] n1_or;
    logic [IN_W-1:0] r1_mag [0:2];
    logic [2:0]      r1_neg;
    logic [IN_W-1:0] r1_or;

    always_comb begin
        logic [IN_W-1:0] v;
        n1_or = '0;
        for (int i = 0; i < 3; i++) begin
            v = i_vec[i*IN_W +: IN_W];
            n1_neg[i] = v[IN_W-1];
            n1_mag[i] = v[IN_W-1] ? (~v + 1'b1) : v;
            n1_or = n1_or | n1_mag[i];
        end
    end

    // msb of the largest magnitude
    logic [PW-1:0]   n2_p;
    logic [IN_W-1:0] r2_mag [0:2];
    logic [2:0]      r2_neg;
    logic [PW-1:0]   r2_p;
    logic            r2_nz;

    always_comb begin
        n2_p = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (r1_or[b]) begin
                n2_p = PW'(b);
            end
        end
    end

    // shift so the msb lands on NORM_MSB
    logic [NORM_W-1:0] n3_mag [0:2];
    logic [NORM_W-1:0] r3_mag [0:2];
    logic [2:0]        r3_neg;
    logic              r3_nz;

    always_comb begin
        logic [IN_W+NORM_MSB-1:0] sh;
        for (int i = 0; i < 3; i++) begin
            sh = {r2_mag[i], {NORM_MSB{1'b0}}} >> r2_p;
            n3_mag[i] = sh[NORM_W-1:0];
        end
    end

    logic [SQ_W-1:0]   r4_sq  [0:2];
    logic [NORM_W-1:0] r4_mag [0:2];
    logic [2:0]        r4_neg;
    logic              r4_nz;

    logic [SUM_W-1:0]  r_srem  [0:ROOT_W];
    logic [ROOT_W-1:0] r_sroot [0:ROOT_W];
    logic [NORM_W-1:0] r_smag  [0:ROOT_W][0:2];
    logic [2:0]        r_sneg  [0:ROOT_W];
    logic              r_snz   [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag <= n1_mag;
            r1_neg <= n1_neg;
            r1_or  <= n1_or;
            r2_mag <= r1_mag;
            r2_neg <= r1_neg;
            r2_p   <= n2_p;
            r2_nz  <= |r1_or;
            r3_mag <= n3_mag;
            r3_neg <= r2_neg;
            r3_nz  <= r2_nz;
            for (int i = 0; i < 3; i++) begin
                r4_sq[i] <= SQ_W'(r3_mag[i]) * SQ_W'(r3_mag[i]);
            end
            r4_mag <= r3_mag;
            r4_neg <= r3_neg;
            r4_nz  <= r3_nz;
            r_srem[0]  <= SUM_W'(r4_sq[0]) + SUM_W'(r4_sq[1]) + SUM_W'(r4_sq[2]);
            r_sroot[0] <= '0;
            r_smag[0]  <= r4_mag;
            r_sneg[0]  <= r4_neg;
            r_snz[0]   <= r4_nz;
        end
    end

    // square root, one result bit per stage
    for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
        localparam int K = ROOT_W - 1 - s;
        logic [63:0] trial;
        logic        take;

        always_comb begin
            trial = (64'(r_sroot[s]) << (K + 1)) + (64'd1 << (2 * K));
            take  = 64'(r_srem[s]) >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_srem[s+1]  <= take ? SUM_W'(64'(r_srem[s]) - trial) : r_srem[s];
                r_sroot[s+1] <= take ? (r_sroot[s] | (ROOT_W'(1) << K)) : r_sroot[s];
                r_smag[s+1]  <= r_smag[s];
                r_sneg[s+1]  <= r_sneg[s];
                r_snz[s+1]   <= r_snz[s];
            end
        end
    end

    logic [NW-1:0]     r_drem [0:QW][0:2];
    logic [QW-1:0]     r_dq   [0:QW][0:2];
    logic [ROOT_W-1:0] r_dlen [0:QW];
    logic [2:0]        r_dneg [0:QW];
    logic              r_dnz  [0:QW];

    // rounded dividend
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_drem[0][i] <= NW'({r_smag[ROOT_W][i], {FRAC_BITS{1'b0}}})
                              + NW'(r_sroot[ROOT_W] >> 1);
                r_dq[0][i]   <= '0;
            end
            r_dlen[0] <= r_sroot[ROOT_W];
            r_dneg[0] <= r_sneg[ROOT_W];
            r_dnz[0]  <= r_snz[ROOT_W];
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar t = 0; t < QW; t++) begin : g_div
        localparam int J = QW - 1 - t;
        logic [DW-1:0] dv;
        logic [2:0]    take;

        always_comb begin
            dv = DW'(r_dlen[t]) << J;
            for (int i = 0; i < 3; i++) begin
                take[i] = DW'(r_drem[t][i]) >= dv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_drem[t+1][i] <= take[i] ? NW'(DW'(r_drem[t][i]) - dv) : r_drem[t][i];
                    r_dq[t+1][i]   <= take[i] ? (r_dq[t][i] | (QW'(1) << J)) : r_dq[t][i];
                end
                r_dlen[t+1] <= r_dlen[t];
                r_dneg[t+1] <= r_dneg[t];
                r_dnz[t+1]  <= r_dnz[t];
            end
        end
    end

    logic [3*UW-1:0] r_ovec;
    logic            r_ook;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_ovec[i*UW +: UW] <= r_dneg[QW][i] ? (~{1'b0, r_dq[QW][i]} + 1'b1)
                                                    : {1'b0, r_dq[QW][i]};
            end
            r_ook <= r_dnz[QW];
        end
    end

    assign o_st.vld = r_vld[LAT-1];
    assign o_st.ok  = r_ook;
    assign o_vec    = r_ovec;
    assign o_side   = r_side[LAT-1];

endmodule

// ===== src/lookat_view_matrix.sv =====
// lookat_view_matrix: right-handed look-at view matrix builder, four row transactions per camera
// camera rate is set by the output port moving one row per cycle while m_axis_tready is high
// the pipeline advances as a whole; it holds while a finished matrix waits for the previous rows to leave
// reset: synchronous active-low i_rst_n clears all valid bits and the row counter
// depends on lvm_pkg and lvm_unit
module lookat_view_matrix #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [((9*WORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // col0, col1, col2, col3
    output logic [((4*WORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // row_index[1:0], degenerate[2]
    output logic [2:0]                            m_axis_tuser,
    output logic                                  m_axis_tlast
);

    localparam int W      = WORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int OUT_DW = ((4*W+7)/8)*8;
    localparam int UW     = F + 2;
    localparam int SW     = lvm_pkg::SCALED_W;
    localparam int NORM_W = lvm_pkg::NORM_W;
    localparam int NMSB   = lvm_pkg::NORM_MSB;
    localparam int ROW_W  = lvm_pkg::ROW_W;
    localparam int DZW    = W + 1;
    localparam int PWU    = $clog2(W);
    localparam int C1W    = SW + UW + 1;
    localparam int C2W    = 2 * UW + 1;
    localparam int AWP    = UW + W - F;
    localparam int BWP    = UW + F + 1;
    localparam int XW     = ((AWP > BWP) ? AWP : BWP) + 4;
    localparam int SZW    = 3*W + 3*SW + 1;
    localparam int SXW    = 3*W + 3*UW + 1;
    localparam int SYW    = 3*W + 6*UW + 1;

    localparam logic signed [XW-1:0] SMAX = XW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] SMIN = -SMAX - XW'(1);
    localparam logic signed [XW-1:0] HALF = XW'(64'sd1 <<< (F - 1));
    localparam logic [W-1:0] ONE_SAT = (F <= W - 2) ? W'(64'd1 << F)
                                                    : W'((64'd1 << (W - 1)) - 64'd1);

    function automatic logic [W-1:0] f_sat(input logic signed [XW-1:0] v);
        logic [W-1:0] res;
        if (v > SMAX) begin
            res = SMAX[W-1:0];
        end else if (v < SMIN) begin
            res = SMIN[W-1:0];
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    logic en;
    logic load;

    // input stage
    logic            r0_v;
    logic [3*W-1:0]  r0_eye;
    logic [3*DZW-1:0] r0_d;
    logic [3*W-1:0]  r0_up;
    logic [3*DZW-1:0] n0_d;

    always_comb begin
        logic signed [DZW-1:0] e;
        logic signed [DZW-1:0] g;
        for (int i = 0; i < 3; i++) begin
            e = DZW'($signed(s_axis_tdata[i*W +: W]));
            g = DZW'($signed(s_axis_tdata[(3+i)*W +: W]));
            n0_d[i*DZW +: DZW] = e - g;
        end
    end

    // up prescale
    logic            r1_v, r2_v, r3_v;
    logic [3*W-1:0]  r1_eye, r2_eye, r3_eye;
    logic [3*DZW-1:0] r1_d, r2_d, r3_d;
    logic [W-1:0]    n1_umag [0:2];
    logic [W-1:0]    r1_umag [0:2];
    logic [W-1:0]    r2_umag [0:2];
    logic [2:0]      n1_uneg, r1_uneg, r2_uneg;
    logic [W-1:0]    n1_uor, r1_uor;
    logic [PWU-1:0]  n2_up, r2_up;
    logic            r2_unz, r3_unz;
    logic [3*SW-1:0] n3_us, r3_us;

    always_comb begin
        logic [W-1:0] v;
        n1_uor = '0;
        for (int i = 0; i < 3; i++) begin
            v = r0_up[i*W +: W];
            n1_uneg[i] = v[W-1];
            n1_umag[i] = v[W-1] ? (~v + 1'b1) : v;
            n1_uor = n1_uor | n1_umag[i];
        end
    end

    always_comb begin
        n2_up = '0;
        for (int b = 0; b < W; b++) begin
            if (r1_uor[b]) begin
                n2_up = PWU'(b);
            end
        end
    end

    always_comb begin
        logic [W+NMSB-1:0] sh;
        logic [SW-1:0]     m;
        for (int i = 0; i < 3; i++) begin
            sh = {r2_umag[i], {NMSB{1'b0}}} >> r2_up;
            m  = {1'b0, sh[NORM_W-1:0]};
            n3_us[i*SW +: SW] = r2_uneg[i] ? (~m + 1'b1) : m;
        end
    end

    // z axis
    lvm_pkg::t_unit_st z_st;
    logic [3*UW-1:0]   z_vec;
    logic [SZW-1:0]    z_side;

    lvm_unit #(.IN_W(DZW), .FRAC_BITS(F), .SIDE_W(SZW)) u_unit_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_vec   (r3_d),
        .i_side  ({r3_unz, r3_us, r3_eye}),
        .o_st    (z_st),
        .o_vec   (z_vec),
        .o_side  (z_side)
    );

    // up cross z
    logic                   r4_v, r5_v;
    logic [3*W-1:0]         r4_eye, r5_eye;
    logic [3*UW-1:0]        r4_z, r5_z;
    logic                   r4_deg, r5_deg;
    logic signed [SW+UW-1:0] n4_pa [0:2];
    logic signed [SW+UW-1:0] n4_pb [0:2];
    logic signed [SW+UW-1:0] r4_pa [0:2];
    logic signed [SW+UW-1:0] r4_pb [0:2];
    logic [3*C1W-1:0]       n5_c, r5_c;

    always_comb begin
        logic [3*SW-1:0]  us;
        logic signed [SW-1:0] aj, ak;
        logic signed [UW-1:0] bj, bk;
        us = z_side[3*W +: 3*SW];
        for (int i = 0; i < 3; i++) begin
            aj = $signed(us[((i+1)%3)*SW +: SW]);
            ak = $signed(us[((i+2)%3)*SW +: SW]);
            bj = $signed(z_vec[((i+1)%3)*UW +: UW]);
            bk = $signed(z_vec[((i+2)%3)*UW +: UW]);
            n4_pa[i] = aj * bk;
            n4_pb[i] = ak * bj;
        end
    end

    always_comb begin
        logic signed [C1W-1:0] c;
        for (int i = 0; i < 3; i++) begin
            c = C1W'(r4_pa[i]) - C1W'(r4_pb[i]);
            n5_c[i*C1W +: C1W] = c;
        end
    end

    // x axis
    lvm_pkg::t_unit_st x_st;
    logic [3*UW-1:0]   x_vec;
    logic [SXW-1:0]    x_side;

    lvm_unit #(.IN_W(C1W), .FRAC_BITS(F), .SIDE_W(SXW)) u_unit_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_vec   (r5_c),
        .i_side  ({r5_deg, r5_z, r5_eye}),
        .o_st    (x_st),
        .o_vec   (x_vec),
        .o_side  (x_side)
    );

    // z cross x
    logic                    r6_v, r7_v;
    logic [3*W-1:0]          r6_eye, r7_eye;
    logic [3*UW-1:0]         r6_z, r7_z, r6_x, r7_x;
    logic                    r6_deg, r7_deg;
    logic signed [2*UW-1:0]  n6_pa [0:2];
    logic signed [2*UW-1:0]  n6_pb [0:2];
    logic signed [2*UW-1:0]  r6_pa [0:2];
    logic signed [2*UW-1:0]  r6_pb [0:2];
    logic [3*C2W-1:0]        n7_c, r7_c;

    always_comb begin
        logic [3*UW-1:0] zz;
        logic signed [UW-1:0] aj, ak, bj, bk;
        zz = x_side[3*W +: 3*UW];
        for (int i = 0; i < 3; i++) begin
            aj = $signed(zz[((i+1)%3)*UW +: UW]);
            ak = $signed(zz[((i+2)%3)*UW +: UW]);
            bj = $signed(x_vec[((i+1)%3)*UW +: UW]);
            bk = $signed(x_vec[((i+2)%3)*UW +: UW]);
            n6_pa[i] = aj * bk;
            n6_pb[i] = ak * bj;
        end
    end

    always_comb begin
        logic signed [C2W-1:0] c;
        for (int i = 0; i < 3; i++) begin
            c = C2W'(r6_pa[i]) - C2W'(r6_pb[i]);
            n7_c[i*C2W +: C2W] = c;
        end
    end

    // y axis
    lvm_pkg::t_unit_st y_st;
    logic [3*UW-1:0]   y_vec;
    logic [SYW-1:0]    y_side;

    lvm_unit #(.IN_W(C2W), .FRAC_BITS(F), .SIDE_W(SYW)) u_unit_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_vec   (r7_c),
        .i_side  ({r7_deg, r7_x, r7_z, r7_eye}),
        .o_st    (y_st),
        .o_vec   (y_vec),
        .o_side  (y_side)
    );

    // translation: rows 0..2 hold x, y, z
    logic [3*UW-1:0]       n8_ax [0:2];
    logic                  r8_v, r9_v, r10_v, r11_v;
    logic                  r8_deg, r9_deg, r10_deg, r11_deg;
    logic [3*UW-1:0]       r8_ax [0:2];
    logic [3*UW-1:0]       r9_ax [0:2];
    logic [3*UW-1:0]       r10_ax [0:2];
    logic signed [AWP-1:0] n8_wp [0:2][0:2];
    logic signed [BWP-1:0] n8_pp [0:2][0:2];
    logic signed [AWP-1:0] r8_wp [0:2][0:2];
    logic signed [BWP-1:0] r8_pp [0:2][0:2];
    logic signed [AWP+1:0] n9_whole [0:2];
    logic signed [BWP+1:0] n9_part [0:2];
    logic signed [AWP+1:0] r9_whole [0:2];
    logic signed [BWP+1:0] r9_part [0:2];
    logic signed [XW-1:0]  n10_t [0:2];
    logic signed [XW-1:0]  r10_t [0:2];
    logic [W-1:0]          n11_e [0:2][0:3];
    logic [W-1:0]          r11_e [0:2][0:3];

    always_comb begin
        logic [3*W-1:0]         eye;
        logic signed [UW-1:0]   u;
        logic signed [W-F-1:0]  a;
        logic signed [F:0]      b;
        eye = y_side[3*W-1:0];
        n8_ax[0] = y_side[3*W+3*UW +: 3*UW];
        n8_ax[1] = y_vec;
        n8_ax[2] = y_side[3*W +: 3*UW];
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
                u = $signed(n8_ax[r][i*UW +: UW]);
                a = $signed(eye[i*W+F +: W-F]);
                b = $signed({1'b0, eye[i*W +: F]});
                n8_wp[r][i] = u * a;
                n8_pp[r][i] = u * b;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n9_whole[r] = (AWP+2)'(r8_wp[r][0]) + (AWP+2)'(r8_wp[r][1])
                        + (AWP+2)'(r8_wp[r][2]);
            n9_part[r]  = (BWP+2)'(r8_pp[r][0]) + (BWP+2)'(r8_pp[r][1])
                        + (BWP+2)'(r8_pp[r][2]);
        end
    end

    always_comb begin
        logic signed [XW-1:0] pw, wh, hs;
        for (int r = 0; r < 3; r++) begin
            pw = XW'(r9_part[r]);
            wh = XW'(r9_whole[r]);
            hs = (HALF - pw) >>> F;
            n10_t[r] = hs - wh;
        end
    end

    always_comb begin
        logic signed [UW-1:0] u;
        logic signed [XW-1:0] ux;
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
                u  = $signed(r10_ax[r][i*UW +: UW]);
                ux = XW'(u);
                n11_e[r][i] = r10_deg ? '0 : f_sat(ux);
            end
            n11_e[r][3] = r10_deg ? '0 : f_sat(r10_t[r]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v  <= 1'b0;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
        end else if (en) begin
            r0_v  <= s_axis_tvalid;
            r1_v  <= r0_v;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= z_st.vld;
            r5_v  <= r4_v;
            r6_v  <= x_st.vld;
            r7_v  <= r6_v;
            r8_v  <= y_st.vld;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= r10_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_eye  <= s_axis_tdata[3*W-1:0];
            r0_d    <= n0_d;
            r0_up   <= s_axis_tdata[6*W +: 3*W];
            r1_eye  <= r0_eye;
            r1_d    <= r0_d;
            r1_umag <= n1_umag;
            r1_uneg <= n1_uneg;
            r1_uor  <= n1_uor;
            r2_eye  <= r1_eye;
            r2_d    <= r1_d;
            r2_umag <= r1_umag;
            r2_uneg <= r1_uneg;
            r2_up   <= n2_up;
            r2_unz  <= |r1_uor;
            r3_eye  <= r2_eye;
            r3_d    <= r2_d;
            r3_us   <= n3_us;
            r3_unz  <= r2_unz;
            r4_eye  <= z_side[3*W-1:0];
            r4_z    <= z_vec;
            r4_deg  <= !z_st.ok || !z_side[SZW-1];
            r4_pa   <= n4_pa;
            r4_pb   <= n4_pb;
            r5_eye  <= r4_eye;
            r5_z    <= r4_z;
            r5_deg  <= r4_deg;
            r5_c    <= n5_c;
            r6_eye  <= x_side[3*W-1:0];
            r6_z    <= x_side[3*W +: 3*UW];
            r6_x    <= x_vec;
            r6_deg  <= x_side[SXW-1] || !x_st.ok;
            r6_pa   <= n6_pa;
            r6_pb   <= n6_pb;
            r7_eye  <= r6_eye;
            r7_z    <= r6_z;
            r7_x    <= r6_x;
            r7_deg  <= r6_deg;
            r7_c    <= n7_c;
            r8_deg  <= y_side[SYW-1] || !y_st.ok;
            r8_ax   <= n8_ax;
            r8_wp   <= n8_wp;
            r8_pp   <= n8_pp;
            r9_deg  <= r8_deg;
            r9_ax   <= r8_ax;
            r9_whole <= n9_whole;
            r9_part <= n9_part;
            r10_deg <= r9_deg;
            r10_ax  <= r9_ax;
            r10_t   <= n10_t;
            r11_deg <= r10_deg;
            r11_e   <= n11_e;
        end
    end

    // row serializer
    logic             r_ov;
    logic [ROW_W-1:0] r_orow;
    logic             r_odeg;
    logic [W-1:0]     r_oc [0:3][0:3];

    assign load = r11_v && (!r_ov || (m_axis_tready && r_orow == lvm_pkg::ROW_LAST));
    assign en   = !r11_v || load;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_orow <= lvm_pkg::ROW_FIRST;
        end else if (load) begin
            r_ov   <= 1'b1;
            r_orow <= lvm_pkg::ROW_FIRST;
        end else if (r_ov && m_axis_tready) begin
            if (r_orow == lvm_pkg::ROW_LAST) begin
                r_ov <= 1'b0;
            end
            r_orow <= r_orow + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int r = 0; r < 3; r++) begin
                r_oc[r] <= r11_e[r];
            end
            r_oc[3][0] <= '0;
            r_oc[3][1] <= '0;
            r_oc[3][2] <= '0;
            r_oc[3][3] <= r11_deg ? '0 : ONE_SAT;
            r_odeg     <= r11_deg;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = OUT_DW'({r_oc[r_orow][3], r_oc[r_orow][2],
                                    r_oc[r_orow][1], r_oc[r_orow][0]});
    assign m_axis_tuser  = {r_odeg, r_orow};
    assign m_axis_tlast  = (r_orow == lvm_pkg::ROW_LAST);

endmodule

// ===== src/lvm_checker.sv =====
// lvm_checker: port-level assertions for lookat_view_matrix, attached by bind
// depends on lvm_pkg and the ports of lookat_view_matrix
module lvm_checker #(
    parameter int WORD_BITS = 32
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((4*WORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    input logic [2:0]                            m_axis_tuser,
    input logic                                  m_axis_tlast
);

    logic o_xfer;
    assign o_xfer = m_axis_tvalid && m_axis_tready;

    // stalled output transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output changed while stalled");

    // rows of one matrix leave in order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_xfer && !m_axis_tlast) |=>
            (m_axis_tuser[1:0] == $past(m_axis_tuser[1:0]) + 2'd1))
        else $error("row index out of sequence");

    // last marker only on the final row
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[1:0] == lvm_pkg::ROW_LAST)))
        else $error("tlast does not match row index");

    // degenerate matrix carries zero entries
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata == '0))
        else $error("degenerate row with nonzero entries");

    // degenerate flag constant across a matrix
    a_deg_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_xfer && !m_axis_tlast) |=> (m_axis_tuser[2] == $past(m_axis_tuser[2])))
        else $error("degenerate flag changed within a matrix");

endmodule

bind lookat_view_matrix lvm_checker #(.WORD_BITS(WORD_BITS)) u_lvm_checker (.*);
